// ===== design/gha_pkg.sv =====
// ----------------------------------------------------------------------------
// gha_pkg
// Shared types and constants of the generational handle allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gha_pkg;

    localparam int INDEX_BITS = 12;
    localparam int GEN_BITS   = 8;
    localparam int DEPTH      = 1 << INDEX_BITS;
    localparam int CNT_BITS   = INDEX_BITS + 1;
    localparam int ACT_BITS   = 2;
    localparam int STAT_BITS  = 2;

    localparam logic [CNT_BITS-1:0] MIN_FREE_RESET = CNT_BITS'(1024);

    // action codes
    localparam logic [ACT_BITS-1:0] ACT_CREATE  = 2'd0;
    localparam logic [ACT_BITS-1:0] ACT_DESTROY = 2'd1;
    localparam logic [ACT_BITS-1:0] ACT_QUERY   = 2'd2;
    localparam logic [ACT_BITS-1:0] ACT_NOP     = 2'd3;

    // status codes
    localparam logic [STAT_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NONE    = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_UNALLOC = 2'd2;

    // register index, taken from paddr[2]
    localparam logic REG_MIN_FREE = 1'b0;

    typedef struct packed {
        logic [ACT_BITS-1:0]   action;
        logic [INDEX_BITS-1:0] handle_index;
        logic [GEN_BITS-1:0]   handle_generation;
    } t_req;

    typedef struct packed {
        logic [INDEX_BITS-1:0] out_index;
        logic [GEN_BITS-1:0]   out_generation;
        logic                  is_alive;
        logic [STAT_BITS-1:0]  status;
    } t_rsp;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_POP_RD,
        S_GEN_RD
    } t_state;

    typedef struct packed {
        logic ld_req;    // capture the accepted item
        logic pop;       // read free list at head, advance head
        logic ld_idx;    // take popped index, read its generation
        logic gen_rd;    // read generation of the requested index
        logic fresh;     // hand out the next fresh index
        logic emit_none; // nothing free
        logic emit_nop;  // no-op echo
        logic finish;    // result from the generation read
    } t_cmd;

    typedef struct packed {
        logic [ACT_BITS-1:0] action;
        logic                can_pop;
        logic                can_fresh;
        logic                out_free;
    } t_stat;

endpackage

`default_nettype wire

// ===== design/gha_ram.sv =====
// ----------------------------------------------------------------------------
// gha_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/gha_ctrl.sv =====
// ----------------------------------------------------------------------------
// gha_ctrl
// Sequencer of the allocator: steps each item through its memory reads.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire gha_pkg::t_stat i_stat,
    output gha_pkg::t_cmd      o_cmd
);

    gha_pkg::t_state r_state;
    gha_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gha_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            gha_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.ld_req = 1'b1;
                    n_state      = gha_pkg::S_DECIDE;
                end
            end
            gha_pkg::S_DECIDE: begin
                case (i_stat.action)
                    gha_pkg::ACT_CREATE: begin
                        if (i_stat.can_pop) begin
                            o_cmd.pop = 1'b1;
                            n_state   = gha_pkg::S_POP_RD;
                        end else if (i_stat.out_free) begin
                            if (i_stat.can_fresh) begin
                                o_cmd.fresh = 1'b1;
                            end else begin
                                o_cmd.emit_none = 1'b1;
                            end
                            n_state = gha_pkg::S_IDLE;
                        end
                    end
                    gha_pkg::ACT_DESTROY, gha_pkg::ACT_QUERY: begin
                        o_cmd.gen_rd = 1'b1;
                        n_state      = gha_pkg::S_GEN_RD;
                    end
                    default: begin
                        if (i_stat.out_free) begin
                            o_cmd.emit_nop = 1'b1;
                            n_state        = gha_pkg::S_IDLE;
                        end
                    end
                endcase
            end
            gha_pkg::S_POP_RD: begin
                o_cmd.ld_idx = 1'b1;
                n_state      = gha_pkg::S_GEN_RD;
            end
            gha_pkg::S_GEN_RD: begin
                // read data holds while the output register is still full
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = gha_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/gha_dp.sv =====
// ----------------------------------------------------------------------------
// gha_dp
// Datapath: generation RAM, free-list RAM, counters and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gha_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire gha_pkg::t_req                 i_req,
    input  wire logic [gha_pkg::CNT_BITS-1:0]  i_min_free,
    input  wire gha_pkg::t_cmd                 i_cmd,
    output gha_pkg::t_stat                     o_stat,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output gha_pkg::t_rsp                      o_out_item
);

    localparam int IW = gha_pkg::INDEX_BITS;
    localparam int GW = gha_pkg::GEN_BITS;
    localparam int CW = gha_pkg::CNT_BITS;

    gha_pkg::t_req   r_req;
    logic [IW-1:0]   r_idx;
    logic [IW-1:0]   r_head;
    logic [IW-1:0]   r_tail;
    logic [CW-1:0]   r_fifo_cnt;
    logic [CW-1:0]   r_alloc;
    logic            r_gen0_live;
    gha_pkg::t_rsp   r_out;
    logic            r_out_valid;

    logic [GW-1:0]   gen_rdata;
    logic [IW-1:0]   fifo_rdata;
    logic            gen_we;
    logic [IW-1:0]   gen_waddr;
    logic [GW-1:0]   gen_wdata;
    logic [IW-1:0]   gen_raddr;
    logic            push;
    logic            in_range;
    logic [GW-1:0]   eff_gen;
    logic            emit;
    gha_pkg::t_rsp   n_out;

    // generation store: entries at or above the fill count read as zero,
    // and index 0 (taken at reset) reads zero until first written
    gha_ram #(.WIDTH(GW), .DEPTH(gha_pkg::DEPTH)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_re    (i_cmd.gen_rd | i_cmd.ld_idx),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    gha_ram #(.WIDTH(IW), .DEPTH(gha_pkg::DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (r_idx),
        .i_re    (i_cmd.pop),
        .i_raddr (r_head),
        .o_rdata (fifo_rdata)
    );

    assign in_range  = {1'b0, r_idx} < r_alloc;
    assign eff_gen   = (!in_range || (r_idx == '0 && !r_gen0_live)) ? '0 : gen_rdata;
    assign gen_raddr = i_cmd.ld_idx ? fifo_rdata : r_idx;

    always_comb begin
        gen_we    = 1'b0;
        gen_waddr = r_idx;
        gen_wdata = eff_gen + 1'b1;
        push      = 1'b0;
        if (i_cmd.fresh) begin
            gen_we    = 1'b1;
            gen_waddr = r_alloc[IW-1:0];
            gen_wdata = '0;
        end else if (i_cmd.finish && r_req.action == gha_pkg::ACT_DESTROY && in_range) begin
            gen_we = 1'b1;
            push   = !r_fifo_cnt[IW];
        end
    end

    assign o_stat.action    = r_req.action;
    assign o_stat.can_pop   = (r_fifo_cnt > i_min_free) ||
                              (r_alloc[IW] && r_fifo_cnt != '0);
    assign o_stat.can_fresh = !r_alloc[IW];
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign emit = i_cmd.fresh | i_cmd.emit_none | i_cmd.emit_nop | i_cmd.finish;

    always_comb begin
        n_out                = '0;
        n_out.out_index      = r_req.handle_index;
        n_out.status         = gha_pkg::ST_OK;
        if (i_cmd.fresh) begin
            n_out.out_index = r_alloc[IW-1:0];
        end else if (i_cmd.emit_none) begin
            n_out.out_index = '0;
            n_out.status    = gha_pkg::ST_NONE;
        end else if (i_cmd.finish) begin
            n_out.out_index      = r_idx;
            n_out.out_generation = eff_gen;
            case (r_req.action)
                gha_pkg::ACT_CREATE: begin
                    n_out.status = gha_pkg::ST_OK;
                end
                gha_pkg::ACT_DESTROY: begin
                    if (in_range) begin
                        n_out.out_generation = gen_wdata;
                    end else begin
                        n_out.status = gha_pkg::ST_UNALLOC;
                    end
                end
                gha_pkg::ACT_QUERY: begin
                    if (in_range) begin
                        n_out.is_alive = (eff_gen == r_req.handle_generation);
                    end else begin
                        n_out.status = gha_pkg::ST_UNALLOC;
                    end
                end
                default: begin
                    n_out.out_generation = '0;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_req) begin
            r_req <= i_req;
            r_idx <= i_req.handle_index;
        end else if (i_cmd.ld_idx) begin
            r_idx <= fifo_rdata;
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_fifo_cnt  <= '0;
            r_alloc     <= CW'(1);
            r_gen0_live <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.pop && !push) begin
                r_head     <= r_head + 1'b1;
                r_fifo_cnt <= r_fifo_cnt - 1'b1;
            end else if (push) begin
                r_tail     <= r_tail + 1'b1;
                r_fifo_cnt <= r_fifo_cnt + 1'b1;
            end
            if (i_cmd.fresh) begin
                r_alloc <= r_alloc + 1'b1;
            end
            if (gen_we && gen_waddr == '0) begin
                r_gen0_live <= 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire

// ===== design/generational_handle_allocator_top.sv =====
// ----------------------------------------------------------------------------
// generational_handle_allocator_top
// Hands out index/generation handles, retires them and checks them for life.
//
// Input channel (i_in_valid / o_in_stall / i_in_item): one request item per
// handshake: create, destroy or alive query. Output channel (o_out_valid /
// i_out_stall / o_out_item): exactly one result item per request, in order.
// An item passes accept and decide for a fresh create, an exhausted create
// or a no-op, adds the generation read for destroy and query, and adds the
// free-list read and then the generation read for a create served from the
// free list; the chain of registered RAM reads (free list, then generation
// store) sets these steps. The result is registered as the last step ends.
// Results sit in an output register; while the receiver stalls it holds,
// the next item is still accepted and then waits before completing.
// Reset clears the counters and marks index 0 as taken with generation 0.
// The generation store needs no clearing pass: entries at or above the fill
// count read as zero. min_free is written over the APB port at address 0.
// ----------------------------------------------------------------------------
`default_nettype none

module generational_handle_allocator_top (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire gha_pkg::t_req i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output gha_pkg::t_rsp      o_out_item,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [gha_pkg::CNT_BITS-1:0] r_min_free;
    gha_pkg::t_cmd                cmd;
    gha_pkg::t_stat               stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_free <= gha_pkg::MIN_FREE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == gha_pkg::REG_MIN_FREE) begin
            r_min_free <= pwdata[gha_pkg::CNT_BITS-1:0];
        end
    end

    assign prdata = (paddr[2] == gha_pkg::REG_MIN_FREE) ? 32'(r_min_free) : '0;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    gha_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_item),
        .i_min_free  (r_min_free),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
